@@ rtl/ptc_pkg.sv @@
// Shared types, constants and multiply helpers for the pressure/temperature compensation pipe.
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TEMP  = 2'd0,
        CFG_PLOW  = 2'd1,
        CFG_PHIGH = 2'd2,
        CFG_P9    = 2'd3
    } t_cfg_idx;

    localparam logic [20:0] P_BASE      = 21'd1048576;
    localparam logic [22:0] T_FINE_OFS  = 23'd128000;
    localparam logic [63:0] P_SCALE     = 64'd3125;
    localparam logic [24:0] ROUND_HALF  = 25'd128;
    localparam logic [63:0] ONE_Q47     = 64'd1 << 47;

    // Partial products of a 64x64 multiply taken modulo 2^64
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_mul_part;

    // Sideband carried through the divider
    typedef struct packed {
        logic        zero;
        logic        neg;
        logic [16:0] temp;
    } t_div_side;

    // First half: three 32x32 products, no adds
    function automatic t_mul_part mul_part(input logic [63:0] a, input logic [63:0] b);
        t_mul_part m;
        m.ll = a[31:0] * b[31:0];
        m.lh = a[31:0] * b[63:32];
        m.hl = a[63:32] * b[31:0];
        return m;
    endfunction

    // Second half: combine partial products
    function automatic logic [63:0] mul_fin(input t_mul_part m);
        return m.ll + {m.lh + m.hl, 32'd0};
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

@@ rtl/ptc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module ptc_div #(
    parameter int W      = 64,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [W-1:0]      i_num,
    input  wire logic [W-1:0]      i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [W-1:0]           o_quo,
    output logic [SIDE_W-1:0]      o_side
);

    logic              r_v    [W];
    logic [W-1:0]      r_rem  [W];
    logic [W-1:0]      r_nq   [W];
    logic [W-1:0]      r_den  [W];
    logic [SIDE_W-1:0] r_side [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic              p_v;
        logic [W-1:0]      p_rem;
        logic [W-1:0]      p_nq;
        logic [W-1:0]      p_den;
        logic [SIDE_W-1:0] p_side;
        logic [W:0]        n_tmp;
        logic [W:0]        n_diff;
        logic              n_qbit;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_nq   = i_num;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_nq   = r_nq[k-1];
            assign p_den  = r_den[k-1];
            assign p_side = r_side[k-1];
        end

        // Shift in next dividend bit, trial subtract
        always_comb begin
            n_tmp  = {p_rem, p_nq[W-1]};
            n_diff = n_tmp - {1'b0, p_den};
            n_qbit = ~n_diff[W];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_qbit ? n_diff[W-1:0] : n_tmp[W-1:0];
                r_nq[k]   <= {p_nq[W-2:0], n_qbit};
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quo   = r_nq[W-1];
    assign o_side  = r_side[W-1];

endmodule
`default_nettype wire

@@ rtl/pressure_temperature_compensation_top.sv @@
// Top level of the barometric pressure/temperature compensation pipeline.
//
// Input channel: i_valid / o_stall carry one request of a raw 20-bit
// temperature and a raw 20-bit pressure. Output channel: o_valid / i_stall
// carry the temperature in 0.01 degC, the pressure in Pa (Q24.8) and a flag
// that is low when the pressure divisor came out zero.
// Calibration words are written through i_cfg_we / i_cfg_idx / i_cfg_data
// while no request is in flight.
// The pipe has 12 stages of temperature and pressure set-up, 64 stages
// of the divider (one quotient bit per stage) and 7 stages of sign fix,
// quadratic correction and clamp. Throughput is one request per cycle
// while no result is held by i_stall. The whole pipe advances together:
// when a result is held by i_stall, every stage holds and o_stall rises;
// bubbles keep flowing otherwise, so nothing is lost or repeated.
// Reset clears all valid bits and the calibration registers to zero.
`timescale 1ns / 1ps
`default_nettype none
module pressure_temperature_compensation_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [19:0] i_raw_temperature,
    input  wire logic [19:0] i_raw_pressure,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_temperature_centi,
    output logic [31:0]      o_pressure_q24_8,
    output logic             o_pressure_valid,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    import ptc_pkg::*;

    localparam int DW     = 64;
    localparam int SIDE_W = $bits(t_div_side);

    // Calibration registers
    logic [47:0] r_tc;
    logic [63:0] r_pl;
    logic [63:0] r_ph;
    logic [15:0] r_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
            r_pl <= '0;
            r_ph <= '0;
            r_p9 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP:  r_tc <= i_cfg_data[47:0];
                CFG_PLOW:  r_pl <= i_cfg_data;
                CFG_PHIGH: r_ph <= i_cfg_data;
                CFG_P9:    r_p9 <= i_cfg_data[15:0];
                default:   r_p9 <= r_p9;
            endcase
        end
    end

    logic        [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8;
    assign t1 = r_tc[15:0];
    assign t2 = r_tc[31:16];
    assign t3 = r_tc[47:32];
    assign p1 = r_pl[15:0];
    assign p2 = r_pl[31:16];
    assign p3 = r_pl[47:32];
    assign p4 = r_pl[63:48];
    assign p5 = r_ph[15:0];
    assign p6 = r_ph[31:16];
    assign p7 = r_ph[47:32];
    assign p8 = r_ph[63:48];

    // Global advance
    logic en;
    assign en      = ~(o_valid & i_stall);
    assign o_stall = ~en;

    logic [11:0] r_va;
    logic [6:0]  r_vb;
    logic        div_v;

    // Stage 1: raw offsets
    logic signed [18:0] n_a0;
    logic signed [16:0] n_d;
    logic signed [18:0] r_s1_a0;
    logic signed [16:0] r_s1_d;
    logic        [19:0] r_s1_rp;
    assign n_a0 = $signed({2'b00, i_raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
    assign n_d  = $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, t1});

    // Stage 2: first temperature products
    logic signed [34:0] r_s2_ma;
    logic signed [33:0] r_s2_dd;
    logic        [19:0] r_s2_rp;

    // Stage 3: shift, quadratic term times T3
    logic signed [31:0] n_a1;
    logic signed [31:0] n_b0;
    logic signed [20:0] r_s3_a1;
    logic signed [35:0] r_s3_mb;
    logic        [19:0] r_s3_rp;
    assign n_a1 = $signed(r_s2_ma[31:0]) >>> 11;
    assign n_b0 = $signed(r_s2_dd[31:0]) >>> 12;

    // Stage 4: fine temperature
    logic signed [31:0] n_b1;
    logic signed [21:0] n_a1w, n_b1w;
    logic signed [21:0] r_s4_tf;
    logic        [19:0] r_s4_rp;
    assign n_b1  = $signed(r_s3_mb[31:0]) >>> 14;
    assign n_a1w = r_s3_a1;
    assign n_b1w = $signed(n_b1[17:0]);

    // Stage 5: temperature output and pressure offset
    logic signed [24:0] n_tf25, n_t5;
    logic signed [22:0] n_tf23, n_x;
    logic signed [16:0] r_s5_temp;
    logic signed [22:0] r_s5_x;
    logic        [19:0] r_s5_rp;
    assign n_tf25 = r_s4_tf;
    assign n_t5   = (n_tf25 <<< 2) + n_tf25 + $signed(ROUND_HALF);
    assign n_tf23 = r_s4_tf;
    assign n_x    = n_tf23 - $signed(T_FINE_OFS);

    // Stage 6: x squared, x*P5, x*P2
    logic signed [45:0] r_s6_xx;
    logic signed [38:0] r_s6_xp5, r_s6_xp2;
    logic signed [16:0] r_s6_temp;
    logic        [19:0] r_s6_rp;

    // Stage 7: x^2*P6, x^2*P3
    logic signed [61:0] r_s7_y1, r_s7_x3;
    logic signed [38:0] r_s7_xp5, r_s7_xp2;
    logic signed [16:0] r_s7_temp;
    logic        [19:0] r_s7_rp;

    // Stage 8: sums for y and divisor base
    logic signed [63:0] n_y1, n_xp5, n_p4, n_x3, n_xp2;
    logic        [63:0] r_s8_y, r_s8_xs;
    logic signed [16:0] r_s8_temp;
    logic        [19:0] r_s8_rp;
    assign n_y1  = r_s7_y1;
    assign n_xp5 = r_s7_xp5;
    assign n_p4  = p4;
    assign n_x3  = r_s7_x3;
    assign n_xp2 = r_s7_xp2;

    // Stage 9: offset divisor base, numerator base
    logic [20:0] n_pb;
    logic [63:0] r_s9_xo, r_s9_pn;
    logic signed [16:0] r_s9_temp;
    assign n_pb = P_BASE - {1'b0, r_s8_rp};

    // Stage 10: partial products
    t_mul_part r_s10_mx, r_s10_mn;
    logic signed [16:0] r_s10_temp;

    // Stage 11: finish products
    logic [63:0] n_mx;
    logic [63:0] r_s11_num, r_s11_den;
    logic signed [16:0] r_s11_temp;
    assign n_mx = mul_fin(r_s10_mx);

    // Stage 12: magnitudes for the divider
    logic [DW-1:0] r_s12_un, r_s12_ud;
    t_div_side     r_s12_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
        end else if (en) begin
            r_va <= {r_va[10:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_a0    <= n_a0;
            r_s1_d     <= n_d;
            r_s1_rp    <= i_raw_pressure;
            r_s2_ma    <= r_s1_a0 * t2;
            r_s2_dd    <= r_s1_d * r_s1_d;
            r_s2_rp    <= r_s1_rp;
            r_s3_a1    <= n_a1[20:0];
            r_s3_mb    <= $signed(n_b0[19:0]) * t3;
            r_s3_rp    <= r_s2_rp;
            r_s4_tf    <= n_a1w + n_b1w;
            r_s4_rp    <= r_s3_rp;
            r_s5_temp  <= n_t5[24:8];
            r_s5_x     <= n_x;
            r_s5_rp    <= r_s4_rp;
            r_s6_xx    <= r_s5_x * r_s5_x;
            r_s6_xp5   <= r_s5_x * p5;
            r_s6_xp2   <= r_s5_x * p2;
            r_s6_temp  <= r_s5_temp;
            r_s6_rp    <= r_s5_rp;
            r_s7_y1    <= r_s6_xx * p6;
            r_s7_x3    <= r_s6_xx * p3;
            r_s7_xp5   <= r_s6_xp5;
            r_s7_xp2   <= r_s6_xp2;
            r_s7_temp  <= r_s6_temp;
            r_s7_rp    <= r_s6_rp;
            r_s8_y     <= n_y1 + (n_xp5 <<< 17) + (n_p4 <<< 35);
            r_s8_xs    <= (n_x3 >>> 8) + (n_xp2 <<< 12);
            r_s8_temp  <= r_s7_temp;
            r_s8_rp    <= r_s7_rp;
            r_s9_xo    <= r_s8_xs + ONE_Q47;
            r_s9_pn    <= ({43'd0, n_pb} << 31) - r_s8_y;
            r_s9_temp  <= r_s8_temp;
            r_s10_mx   <= mul_part(r_s9_xo, {48'd0, p1});
            r_s10_mn   <= mul_part(r_s9_pn, P_SCALE);
            r_s10_temp <= r_s9_temp;
            r_s11_den  <= $signed(n_mx) >>> 33;
            r_s11_num  <= mul_fin(r_s10_mn);
            r_s11_temp <= r_s10_temp;
            r_s12_un   <= r_s11_num[63] ? (64'd0 - r_s11_num) : r_s11_num;
            r_s12_ud   <= r_s11_den[63] ? (64'd0 - r_s11_den) : r_s11_den;
            r_s12_side <= '{zero: (r_s11_den == 64'd0),
                            neg:  r_s11_num[63] ^ r_s11_den[63],
                            temp: r_s11_temp};
        end
    end

    // Divider
    logic [DW-1:0]     div_q;
    logic [SIDE_W-1:0] div_side_raw;
    t_div_side         div_side;
    assign div_side = div_side_raw;

    ptc_div #(
        .W      (DW),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_va[11]),
        .i_num   (r_s12_un),
        .i_den   (r_s12_ud),
        .i_side  (r_s12_side),
        .o_valid (div_v),
        .o_quo   (div_q),
        .o_side  (div_side_raw)
    );

    // Post-divide stages
    logic [63:0]        r_q0_q;
    t_div_side          r_q0_side;
    logic [63:0]        n_ps;
    t_mul_part          r_d1_m9, r_d1_m8;
    logic [63:0]        r_d1_ps, r_d1_q;
    t_div_side          r_d1_side;
    logic [63:0]        r_d2_p9ps, r_d2_p8q, r_d2_ps, r_d2_q;
    t_div_side          r_d2_side;
    t_mul_part          r_d3_ma;
    logic [63:0]        r_d3_p8q, r_d3_q;
    t_div_side          r_d3_side;
    logic [63:0]        n_ma;
    logic [63:0]        r_d4_a, r_d4_b, r_d4_q;
    t_div_side          r_d4_side;
    logic [63:0]        r_d5_s;
    t_div_side          r_d5_side;
    logic signed [63:0] n_pf;
    logic [31:0]        n_pres;
    logic [31:0]        r_o_pres;
    logic signed [16:0] r_o_temp;
    logic               r_o_pv;

    assign n_ps = $signed(r_q0_q) >>> 13;
    assign n_ma = mul_fin(r_d3_ma);
    assign n_pf = ($signed(r_d5_s) >>> 8) + ($signed(sext16(p7)) <<< 4);

    // Clamp to unsigned 32 bits
    always_comb begin
        if (n_pf[63]) begin
            n_pres = '0;
        end else if (|n_pf[62:32]) begin
            n_pres = '1;
        end else begin
            n_pres = n_pf[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
        end else if (en) begin
            r_vb <= {r_vb[5:0], div_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q0_q    <= div_side.neg ? (64'd0 - div_q) : div_q;
            r_q0_side <= div_side;
            r_d1_m9   <= mul_part(sext16(r_p9), n_ps);
            r_d1_m8   <= mul_part(sext16(p8), r_q0_q);
            r_d1_ps   <= n_ps;
            r_d1_q    <= r_q0_q;
            r_d1_side <= r_q0_side;
            r_d2_p9ps <= mul_fin(r_d1_m9);
            r_d2_p8q  <= mul_fin(r_d1_m8);
            r_d2_ps   <= r_d1_ps;
            r_d2_q    <= r_d1_q;
            r_d2_side <= r_d1_side;
            r_d3_ma   <= mul_part(r_d2_p9ps, r_d2_ps);
            r_d3_p8q  <= r_d2_p8q;
            r_d3_q    <= r_d2_q;
            r_d3_side <= r_d2_side;
            r_d4_a    <= $signed(n_ma) >>> 25;
            r_d4_b    <= $signed(r_d3_p8q) >>> 19;
            r_d4_q    <= r_d3_q;
            r_d4_side <= r_d3_side;
            r_d5_s    <= r_d4_q + r_d4_a + r_d4_b;
            r_d5_side <= r_d4_side;
            r_o_temp  <= r_d5_side.temp;
            r_o_pv    <= ~r_d5_side.zero;
            r_o_pres  <= r_d5_side.zero ? 32'd0 : n_pres;
        end
    end

    assign o_valid             = r_vb[6];
    assign o_temperature_centi = {{15{r_o_temp[16]}}, r_o_temp};
    assign o_pressure_q24_8    = r_o_pres;
    assign o_pressure_valid    = r_o_pv;

endmodule
`default_nettype wire
